// ===== rtl/core/tbbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbbs_pkg
// Shared types, constants and tables for the transformed box bounds block:
// command and result codes, CORDIC constants, the rotation microcode.
// ----------------------------------------------------------------------------
package tbbs_pkg;

  // Widths of the internal datapath
  localparam int ZW    = 36;   // CORDIC angle accumulator, Q.30
  localparam int MW    = 34;   // multiplier operand / coefficient
  localparam int PW    = 2 * MW;
  localparam int XW    = PW + 2; // widened sum for shifting and saturation
  localparam int CORDIC_STEPS = 28;

  typedef logic signed [MW-1:0] coef_t;
  typedef logic signed [31:0]   word_t;

  // Input commands
  localparam logic [2:0] CMD_BOX_MIN  = 3'd0;
  localparam logic [2:0] CMD_BOX_MAX  = 3'd1;
  localparam logic [2:0] CMD_SCALE    = 3'd2;
  localparam logic [2:0] CMD_ANGLES   = 3'd3;
  localparam logic [2:0] CMD_POSITION = 3'd4;
  localparam logic [2:0] CMD_FINISH   = 3'd5;

  // Result kinds
  localparam logic [2:0] KIND_MIN    = 3'd0;
  localparam logic [2:0] KIND_MAX    = 3'd1;
  localparam logic [2:0] KIND_CENTER = 3'd2;
  localparam logic [2:0] KIND_SIZE   = 3'd3;
  localparam logic [2:0] KIND_RADIUS = 3'd4;

  // CORDIC constants, Q.30
  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam coef_t                GAIN_Q30    = 34'sd652032874;

  // CORDIC unit handshake
  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } cord_req_t;

  typedef struct packed {
    logic  done;
    coef_t cos_v;
    coef_t sin_v;
  } cord_rsp_t;

  // Square root unit handshake
  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } root_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } root_rsp_t;

  // arctan(2^-i) in Q.30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = 36'sd843314857;
      5'd1:    r = 36'sd497837829;
      5'd2:    r = 36'sd263043837;
      5'd3:    r = 36'sd133525159;
      5'd4:    r = 36'sd67021688;
      5'd5:    r = 36'sd33543516;
      5'd6:    r = 36'sd16775851;
      5'd7:    r = 36'sd8388437;
      5'd8:    r = 36'sd4194283;
      5'd9:    r = 36'sd2097149;
      default: r = $signed(36'd1 << (5'd30 - i));
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic word_t sat32(input logic signed [XW-1:0] v);
    word_t r;
    if (v > $signed({{(XW-32){1'b0}}, 32'h7fff_ffff}))
      r = 32'sh7fff_ffff;
    else if (v < $signed({{(XW-32){1'b1}}, 32'h8000_0000}))
      r = 32'sh8000_0000;
    else
      r = v[31:0];
    return r;
  endfunction

  // Corner transform microcode: one multiply per step
  localparam logic [1:0] OP_SCALE = 2'd0;  // p[dst_a] = sat(prod >> F)
  localparam logic [1:0] OP_FIRST = 2'd1;  // acc = prod
  localparam logic [1:0] OP_HOLD  = 2'd2;  // hold = sat((acc+prod) >> 30)
  localparam logic [1:0] OP_WRITE = 2'd3;  // p[dst_a] = hold, p[dst_b] = sat(...)

  localparam logic [3:0] B_SC0 = 4'd0;
  localparam logic [3:0] B_SC1 = 4'd1;
  localparam logic [3:0] B_SC2 = 4'd2;
  localparam logic [3:0] B_CX  = 4'd3;
  localparam logic [3:0] B_SX  = 4'd4;
  localparam logic [3:0] B_NSX = 4'd5;
  localparam logic [3:0] B_CY  = 4'd6;
  localparam logic [3:0] B_SY  = 4'd7;
  localparam logic [3:0] B_NSY = 4'd8;
  localparam logic [3:0] B_CZ  = 4'd9;
  localparam logic [3:0] B_SZ  = 4'd10;
  localparam logic [3:0] B_NSZ = 4'd11;

  localparam logic [3:0] LAST_UOP = 4'd14;

  typedef struct packed {
    logic [1:0] a_sel;
    logic [3:0] b_sel;
    logic [1:0] op;
    logic [1:0] dst_a;
    logic [1:0] dst_b;
  } uop_t;

  // Scale, then rotate about X, Y and Z
  function automatic uop_t uop_at(input logic [3:0] s);
    uop_t u;
    case (s)
      4'd0:    u = '{2'd0, B_SC0, OP_SCALE, 2'd0, 2'd0};
      4'd1:    u = '{2'd1, B_SC1, OP_SCALE, 2'd1, 2'd0};
      4'd2:    u = '{2'd2, B_SC2, OP_SCALE, 2'd2, 2'd0};
      4'd3:    u = '{2'd1, B_CX,  OP_FIRST, 2'd0, 2'd0};
      4'd4:    u = '{2'd2, B_NSX, OP_HOLD,  2'd0, 2'd0};
      4'd5:    u = '{2'd1, B_SX,  OP_FIRST, 2'd0, 2'd0};
      4'd6:    u = '{2'd2, B_CX,  OP_WRITE, 2'd1, 2'd2};
      4'd7:    u = '{2'd0, B_CY,  OP_FIRST, 2'd0, 2'd0};
      4'd8:    u = '{2'd2, B_SY,  OP_HOLD,  2'd0, 2'd0};
      4'd9:    u = '{2'd2, B_CY,  OP_FIRST, 2'd0, 2'd0};
      4'd10:   u = '{2'd0, B_NSY, OP_WRITE, 2'd0, 2'd2};
      4'd11:   u = '{2'd0, B_CZ,  OP_FIRST, 2'd0, 2'd0};
      4'd12:   u = '{2'd1, B_NSZ, OP_HOLD,  2'd0, 2'd0};
      4'd13:   u = '{2'd0, B_SZ,  OP_FIRST, 2'd0, 2'd0};
      4'd14:   u = '{2'd1, B_CZ,  OP_WRITE, 2'd0, 2'd1};
      default: u = '{2'd0, B_SC0, OP_SCALE, 2'd0, 2'd0};
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/core/tbbs_ram.sv =====
// ----------------------------------------------------------------------------
// tbbs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tbbs_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [0:D-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tbbs_cordic.sv =====
// ----------------------------------------------------------------------------
// tbbs_cordic
// Iterative rotation-mode CORDIC: reduces a Q3.12 angle to [-pi/2, pi/2],
// then runs one micro-rotation per cycle to produce cosine and sine in Q.30.
// ----------------------------------------------------------------------------
module tbbs_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tbbs_pkg::cord_req_t   req,
  output tbbs_pkg::cord_rsp_t   rsp
);
  import tbbs_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RED  = 2'd1;
  localparam logic [1:0] C_FOLD = 2'd2;
  localparam logic [1:0] C_ITER = 2'd3;

  localparam logic [4:0] LAST_ITER = 5'(CORDIC_STEPS - 1);

  logic [1:0]           st_r;
  logic [4:0]           i_r;
  logic signed [ZW-1:0] z_r;
  coef_t                x_r;
  coef_t                y_r;
  logic                 neg_r;
  logic                 done_r;

  logic signed [ZW-1:0] a_w;
  coef_t                xs_w;
  coef_t                ys_w;

  assign a_w  = atan_q30(i_r);
  assign xs_w = x_r >>> i_r;
  assign ys_w = y_r >>> i_r;

  // Sequencer: reduce, fold, then iterate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        C_IDLE: begin
          if (req.start) begin
            z_r   <= $signed({{(ZW-34){req.angle[15]}}, req.angle, 18'd0});
            x_r   <= GAIN_Q30;
            y_r   <= '0;
            neg_r <= 1'b0;
            st_r  <= C_RED;
          end
        end
        C_RED: begin
          if (z_r > PI_Q30) begin
            z_r <= z_r - TWO_PI_Q30;
          end else if (z_r < -PI_Q30) begin
            z_r <= z_r + TWO_PI_Q30;
          end else begin
            st_r <= C_FOLD;
          end
        end
        C_FOLD: begin
          if (z_r > HALF_PI_Q30) begin
            z_r   <= z_r - PI_Q30;
            neg_r <= 1'b1;
          end else if (z_r < -HALF_PI_Q30) begin
            z_r   <= z_r + PI_Q30;
            neg_r <= 1'b1;
          end
          i_r  <= '0;
          st_r <= C_ITER;
        end
        C_ITER: begin
          if (!z_r[ZW-1]) begin
            x_r <= x_r - ys_w;
            y_r <= y_r + xs_w;
            z_r <= z_r - a_w;
          end else begin
            x_r <= x_r + ys_w;
            y_r <= y_r - xs_w;
            z_r <= z_r + a_w;
          end
          i_r <= i_r + 5'd1;
          if (i_r == LAST_ITER) begin
            st_r   <= C_IDLE;
            done_r <= 1'b1;
          end
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  // Results, negated when the angle was folded
  assign rsp.done  = done_r;
  assign rsp.cos_v = neg_r ? -x_r : x_r;
  assign rsp.sin_v = neg_r ? -y_r : y_r;

endmodule

// ===== rtl/core/tbbs_isqrt.sv =====
// ----------------------------------------------------------------------------
// tbbs_isqrt
// Iterative floor integer square root of a 64-bit value, one result bit
// per cycle.
// ----------------------------------------------------------------------------
module tbbs_isqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbbs_pkg::root_req_t  req,
  output tbbs_pkg::root_rsp_t  rsp
);
  import tbbs_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [64:0] trial_w;

  assign trial_w = {1'b0, res_r} + {1'b0, bit_r};

  // One digit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          v_r    <= req.value;
          res_r  <= '0;
          bit_r  <= 64'd1 << 62;
          busy_r <= 1'b1;
        end
      end else begin
        if ({1'b0, v_r} >= trial_w) begin
          v_r   <= v_r - trial_w[63:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[31:0];

endmodule

// ===== rtl/core/transformed_box_bounds_with_sphere_core.sv =====
// ----------------------------------------------------------------------------
// transformed_box_bounds_with_sphere_core
// Bounds of a set of scaled, rotated and translated boxes, plus the radius
// of the sphere around their center, on one shared multiplier.
// ----------------------------------------------------------------------------
// Load commands are stored directly in the part registers. A commit runs the
// CORDIC for each of the three angles, then for each of the 8 corners a load,
// 15 multiplies through the shared multiplier and a translate into the store.
// Finish reads each stored corner from RAM and sums its three squares on the
// shared multiplier, then takes the root, then makes 5 result transfers.
// Synchronous reset clears the run; the corner RAMs need no clearing pass.
module transformed_box_bounds_with_sphere_core #(
  parameter int MAX_PARTS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  tbbs_pkg::word_t    in_value_x,
  input  tbbs_pkg::word_t    in_value_y,
  input  tbbs_pkg::word_t    in_value_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output tbbs_pkg::word_t    out_x,
  output tbbs_pkg::word_t    out_y,
  output tbbs_pkg::word_t    out_z,
  output logic               out_last
);
  import tbbs_pkg::*;

  localparam int DEPTH = MAX_PARTS * 8;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CSTART = 4'd1;
  localparam logic [3:0] S_CWAIT  = 4'd2;
  localparam logic [3:0] S_LOAD   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_XLATE  = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_RD     = 4'd8;
  localparam logic [3:0] S_SQMUL  = 4'd9;
  localparam logic [3:0] S_SQACC  = 4'd10;
  localparam logic [3:0] S_SQCMP  = 4'd11;
  localparam logic [3:0] S_RSTART = 4'd12;
  localparam logic [3:0] S_RWAIT  = 4'd13;
  localparam logic [3:0] S_EMIT   = 4'd14;

  // Part vectors
  word_t bmin_r [0:2];
  word_t bmax_r [0:2];
  word_t scl_r  [0:2];
  word_t ang_r  [0:2];
  word_t pos_r  [0:2];

  // Sequencer and datapath registers
  logic [3:0]           st_r;
  logic [3:0]           step_r;
  logic [2:0]           corner_r;
  logic [1:0]           axis_r;
  logic [1:0]           sqk_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        idx_r;
  coef_t                cos_r [0:2];
  coef_t                sin_r [0:2];
  word_t                p_r   [0:2];
  word_t                hold_r;
  logic signed [XW-1:0] acc_r;
  logic signed [PW-1:0] prod_r;
  word_t                min_r [0:2];
  word_t                max_r [0:2];
  logic [63:0]          sq_r;
  logic [63:0]          best_r;

  // Result registers
  logic                 ov_r;
  logic [2:0]           kind_r;
  word_t                em_mn_r [0:2];
  word_t                em_mx_r [0:2];
  word_t                ce_r    [0:2];
  word_t                sz_r    [0:2];
  word_t                rad_r;

  // Combinational helpers
  uop_t                 uop_w;
  coef_t                mul_a_w;
  coef_t                mul_b_w;
  logic signed [XW-1:0] pext_w;
  logic signed [XW-1:0] rsum_w;
  word_t                scaled_w;
  word_t                rot_w;
  word_t                xl_w   [0:2];
  word_t                rd_w   [0:2];
  logic signed [32:0]   diff_w [0:2];
  logic signed [32:0]   mid_w  [0:2];
  logic                 in_xfer_w;
  logic                 out_xfer_w;
  logic                 skip_w;

  cord_req_t cord_req;
  cord_rsp_t cord_rsp;
  root_req_t root_req;
  root_rsp_t root_rsp;

  assign in_xfer_w  = in_valid && in_ready;
  assign out_xfer_w = out_valid && out_ready;
  assign skip_w     = ({1'b0, cnt_r} + (CW+1)'(8)) > (CW+1)'(DEPTH);
  assign uop_w      = uop_at(step_r);

  // Shared CORDIC and square root units
  assign cord_req.start = (st_r == S_CSTART);
  assign cord_req.angle = ang_r[axis_r][15:0];

  tbbs_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .rsp   (cord_rsp)
  );

  assign root_req.start = (st_r == S_RSTART);
  assign root_req.value = best_r;

  tbbs_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (root_req),
    .rsp   (root_rsp)
  );

  // Corner store, one RAM per axis
  for (genvar k = 0; k < 3; k++) begin : g_corner
    tbbs_ram #(
      .W (32),
      .D (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (st_r == S_XLATE),
      .waddr (cnt_r[AW-1:0]),
      .wdata (xl_w[k]),
      .raddr (idx_r[AW-1:0]),
      .rdata (rd_w[k])
    );
  end

  // Per-axis translate, center and distance terms
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xl_w[k]   = sat32(XW'(p_r[k]) + XW'(pos_r[k]));
      diff_w[k] = 33'(rd_w[k]) - 33'(ce_r[k]);
      mid_w[k]  = (33'(min_r[k]) + 33'(max_r[k])) >>> 1;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    if (st_r == S_SQMUL) begin
      mul_a_w = MW'(diff_w[sqk_r]);
      mul_b_w = MW'(diff_w[sqk_r]);
    end else begin
      mul_a_w = MW'(p_r[uop_w.a_sel]);
      case (uop_w.b_sel)
        B_SC0:   mul_b_w = MW'(scl_r[0]);
        B_SC1:   mul_b_w = MW'(scl_r[1]);
        B_SC2:   mul_b_w = MW'(scl_r[2]);
        B_CX:    mul_b_w = cos_r[0];
        B_SX:    mul_b_w = sin_r[0];
        B_NSX:   mul_b_w = -sin_r[0];
        B_CY:    mul_b_w = cos_r[1];
        B_SY:    mul_b_w = sin_r[1];
        B_NSY:   mul_b_w = -sin_r[1];
        B_CZ:    mul_b_w = cos_r[2];
        B_SZ:    mul_b_w = sin_r[2];
        B_NSZ:   mul_b_w = -sin_r[2];
        default: mul_b_w = '0;
      endcase
    end
  end

  // Product consumers: scale and rotation sums
  assign pext_w   = XW'(prod_r);
  assign rsum_w   = pext_w + acc_r;
  assign scaled_w = sat32(pext_w >>> FRAC_BITS);
  assign rot_w    = sat32(rsum_w >>> 30);

  // Part vector registers
  always_ff @(posedge clk) begin
    if (in_xfer_w) begin
      case (in_command)
        CMD_BOX_MIN: begin
          bmin_r[0] <= in_value_x; bmin_r[1] <= in_value_y; bmin_r[2] <= in_value_z;
        end
        CMD_BOX_MAX: begin
          bmax_r[0] <= in_value_x; bmax_r[1] <= in_value_y; bmax_r[2] <= in_value_z;
        end
        CMD_SCALE: begin
          scl_r[0] <= in_value_x; scl_r[1] <= in_value_y; scl_r[2] <= in_value_z;
        end
        CMD_ANGLES: begin
          ang_r[0] <= in_value_x; ang_r[1] <= in_value_y; ang_r[2] <= in_value_z;
        end
        CMD_POSITION: begin
          pos_r[0] <= in_value_x; pos_r[1] <= in_value_y; pos_r[2] <= in_value_z;
        end
        default: ;
      endcase
    end
  end

  // Main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ov_r   <= 1'b0;
      kind_r <= KIND_MIN;
      cnt_r  <= '0;
      for (int k = 0; k < 3; k++) begin
        min_r[k] <= 32'sh7fff_ffff;
        max_r[k] <= 32'sh8000_0000;
      end
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (in_xfer_w) begin
            if (in_command == CMD_POSITION && !skip_w) begin
              axis_r <= 2'd0;
              st_r   <= S_CSTART;
            end else if (in_command == CMD_FINISH) begin
              st_r <= S_FIN;
            end
          end
        end
        S_CSTART: st_r <= S_CWAIT;
        S_CWAIT: begin
          if (cord_rsp.done) begin
            cos_r[axis_r] <= cord_rsp.cos_v;
            sin_r[axis_r] <= cord_rsp.sin_v;
            if (axis_r == 2'd2) begin
              corner_r <= 3'd0;
              st_r     <= S_LOAD;
            end else begin
              axis_r <= axis_r + 2'd1;
              st_r   <= S_CSTART;
            end
          end
        end
        S_LOAD: begin
          p_r[0] <= corner_r[0] ? bmax_r[0] : bmin_r[0];
          p_r[1] <= corner_r[1] ? bmax_r[1] : bmin_r[1];
          p_r[2] <= corner_r[2] ? bmax_r[2] : bmin_r[2];
          step_r <= 4'd0;
          st_r   <= S_MUL;
        end
        S_MUL: begin
          prod_r <= mul_a_w * mul_b_w;
          st_r   <= S_ACC;
        end
        S_ACC: begin
          case (uop_w.op)
            OP_SCALE: p_r[uop_w.dst_a] <= scaled_w;
            OP_FIRST: acc_r <= pext_w;
            OP_HOLD:  hold_r <= rot_w;
            default: begin
              p_r[uop_w.dst_a] <= hold_r;
              p_r[uop_w.dst_b] <= rot_w;
            end
          endcase
          if (step_r == LAST_UOP) begin
            st_r <= S_XLATE;
          end else begin
            step_r <= step_r + 4'd1;
            st_r   <= S_MUL;
          end
        end
        S_XLATE: begin
          for (int k = 0; k < 3; k++) begin
            if (xl_w[k] < min_r[k]) min_r[k] <= xl_w[k];
            if (xl_w[k] > max_r[k]) max_r[k] <= xl_w[k];
          end
          cnt_r <= cnt_r + 1'b1;
          if (corner_r == 3'd7) begin
            st_r <= S_IDLE;
          end else begin
            corner_r <= corner_r + 3'd1;
            st_r     <= S_LOAD;
          end
        end
        S_FIN: begin
          if (cnt_r == '0) begin
            for (int k = 0; k < 3; k++) begin
              em_mn_r[k] <= '0;
              em_mx_r[k] <= '0;
              ce_r[k]    <= '0;
              sz_r[k]    <= '0;
            end
            rad_r  <= '0;
            kind_r <= KIND_MIN;
            ov_r   <= 1'b1;
            st_r   <= S_EMIT;
          end else begin
            for (int k = 0; k < 3; k++) begin
              em_mn_r[k] <= min_r[k];
              em_mx_r[k] <= max_r[k];
              ce_r[k]    <= mid_w[k][31:0];
              sz_r[k]    <= sat32(XW'(max_r[k]) - XW'(min_r[k]));
            end
            best_r <= '0;
            idx_r  <= '0;
            st_r   <= S_RD;
          end
        end
        S_RD: begin
          sq_r  <= '0;
          sqk_r <= 2'd0;
          st_r  <= S_SQMUL;
        end
        S_SQMUL: begin
          prod_r <= mul_a_w * mul_b_w;
          st_r   <= S_SQACC;
        end
        S_SQACC: begin
          sq_r <= sq_r + prod_r[63:0];
          if (sqk_r == 2'd2) begin
            st_r <= S_SQCMP;
          end else begin
            sqk_r <= sqk_r + 2'd1;
            st_r  <= S_SQMUL;
          end
        end
        S_SQCMP: begin
          if (sq_r > best_r) best_r <= sq_r;
          if ((idx_r + 1'b1) == cnt_r) begin
            st_r <= S_RSTART;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r  <= S_RD;
          end
        end
        S_RSTART: st_r <= S_RWAIT;
        S_RWAIT: begin
          if (root_rsp.done) begin
            rad_r  <= root_rsp.root[31] ? 32'sh7fff_ffff : root_rsp.root;
            kind_r <= KIND_MIN;
            ov_r   <= 1'b1;
            st_r   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_xfer_w) begin
            if (kind_r == KIND_RADIUS) begin
              ov_r  <= 1'b0;
              cnt_r <= '0;
              for (int k = 0; k < 3; k++) begin
                min_r[k] <= 32'sh7fff_ffff;
                max_r[k] <= 32'sh8000_0000;
              end
              st_r <= S_IDLE;
            end else begin
              kind_r <= kind_r + 3'd1;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Ports
  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_kind  = kind_r;
  assign out_last  = (kind_r == KIND_RADIUS);

  always_comb begin
    case (kind_r)
      KIND_MIN: begin
        out_x = em_mn_r[0]; out_y = em_mn_r[1]; out_z = em_mn_r[2];
      end
      KIND_MAX: begin
        out_x = em_mx_r[0]; out_y = em_mx_r[1]; out_z = em_mx_r[2];
      end
      KIND_CENTER: begin
        out_x = ce_r[0]; out_y = ce_r[1]; out_z = ce_r[2];
      end
      KIND_SIZE: begin
        out_x = sz_r[0]; out_y = sz_r[1]; out_z = sz_r[2];
      end
      default: begin
        out_x = rad_r; out_y = '0; out_z = '0;
      end
    endcase
  end

  // Checks
  a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while results pending");

  a_last_only_on_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_kind == KIND_RADIUS))
    else $error("last flag on a non-radius result");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("corner count beyond store depth");

  a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer_w && out_last) |=> (cnt_r == '0 && in_ready))
    else $error("run not cleared after radius transfer");

  a_commit_stays_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_XLATE) |-> (cnt_r < CW'(DEPTH)))
    else $error("corner write beyond store depth");

endmodule

// ===== sim/transformed_box_bounds_with_sphere_core_tb.sv =====
// ----------------------------------------------------------------------------
// transformed_box_bounds_with_sphere_core_tb
// Self-checking bench for the transformed box bounds core: drives part loads,
// commits and finishes with random idling, predicts the min, max, center,
// size and radius results in-bench and compares each result transfer.
// ----------------------------------------------------------------------------
module transformed_box_bounds_with_sphere_core_tb;
  import tbbs_pkg::*;

  localparam int NUM_PARTS   = 32;
  localparam int CORNER_MAX  = NUM_PARTS * 8;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 500;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    word_t      x;
    word_t      y;
    word_t      z;
    logic       last;
  } bounds_res_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_command = '0;
  word_t      in_value_x = '0;
  word_t      in_value_y = '0;
  word_t      in_value_z = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_kind;
  word_t      out_x;
  word_t      out_y;
  word_t      out_z;
  logic       out_last;

  transformed_box_bounds_with_sphere_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_value_x(in_value_x), .in_value_y(in_value_y), .in_value_z(in_value_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_last(out_last)
  );

  // Predictor state
  word_t part_vec [5][3];
  word_t run_min [3];
  word_t run_max [3];
  word_t corn_x [CORNER_MAX];
  word_t corn_y [CORNER_MAX];
  word_t corn_z [CORNER_MAX];
  int    corn_count;
  bounds_res_t bounds_q [$];

  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int mismatches = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  longint atan_tab [10] = '{843314857, 497837829, 263043837, 133525159, 67021688,
                            33543516, 16775851, 8388437, 4194283, 2097149};

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic word_t clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Rotation-mode CORDIC on a Q3.12 angle, Q.30 outputs
  task automatic cordic_sin_cos(input word_t w, output longint c, output longint s);
    longint z, x, y, t, a;
    bit     neg;
    z = longint'($signed(w[15:0])) * 262144;
    x = 652032874;
    y = 0;
    neg = 0;
    while (z > 64'sd3373259426) z -= 64'sd6746518852;
    while (z < -64'sd3373259426) z += 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; neg = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; neg = 1;
    end
    for (int i = 0; i < 28; i++) begin
      a = (i < 10) ? atan_tab[i] : (64'sd1 <<< (30 - i));
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= a;
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += a;
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic word_t rot_mix(input word_t a, input longint ca,
                                    input word_t b, input longint cb);
    return clamp32((longint'(a) * ca + longint'(b) * cb) >>> 30);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv; res = (res >> 1) + bitv;
      end else res >>= 1;
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic clear_bounds();
    for (int k = 0; k < 3; k++) begin
      run_min[k] = 32'sh7fff_ffff;
      run_max[k] = 32'sh8000_0000;
    end
    corn_count = 0;
  endtask

  // Append one expected result at the tail of the queue
  task automatic expect_result(input bounds_res_t r);
    bounds_q.insert(bounds_q.size(), r);
  endtask

  // Transform the eight corners of the loaded part and fold them in
  task automatic commit_corners();
    longint cx, sx, cy, sy, cz, sz;
    word_t  p [3];
    word_t  a, b;
    if (corn_count + 8 > CORNER_MAX) return;
    cordic_sin_cos(part_vec[3][0], cx, sx);
    cordic_sin_cos(part_vec[3][1], cy, sy);
    cordic_sin_cos(part_vec[3][2], cz, sz);
    for (int n = 0; n < 8; n++) begin
      p[0] = part_vec[n[0] ? 1 : 0][0];
      p[1] = part_vec[n[1] ? 1 : 0][1];
      p[2] = part_vec[n[2] ? 1 : 0][2];
      for (int k = 0; k < 3; k++)
        p[k] = clamp32((longint'(p[k]) * longint'(part_vec[2][k])) >>> 16);
      a = rot_mix(p[1], cx, p[2], -sx); b = rot_mix(p[1], sx, p[2], cx);
      p[1] = a; p[2] = b;
      a = rot_mix(p[0], cy, p[2], sy); b = rot_mix(p[2], cy, p[0], -sy);
      p[0] = a; p[2] = b;
      a = rot_mix(p[0], cz, p[1], -sz); b = rot_mix(p[0], sz, p[1], cz);
      p[0] = a; p[1] = b;
      for (int k = 0; k < 3; k++) begin
        p[k] = clamp32(longint'(p[k]) + longint'(part_vec[4][k]));
        if (p[k] < run_min[k]) run_min[k] = p[k];
        if (p[k] > run_max[k]) run_max[k] = p[k];
      end
      corn_x[corn_count] = p[0];
      corn_y[corn_count] = p[1];
      corn_z[corn_count] = p[2];
      corn_count++;
    end
  endtask

  // Queue the five finish results, then clear for the next shape
  task automatic finish_bounds();
    word_t mn [3], mx [3], ce [3], sz [3];
    word_t radius;
    longint dx, dy, dz;
    longint unsigned best, d, r;
    for (int k = 0; k < 3; k++) begin
      mn[k] = '0; mx[k] = '0; ce[k] = '0; sz[k] = '0;
    end
    radius = '0;
    if (corn_count > 0) begin
      best = 0;
      for (int k = 0; k < 3; k++) begin
        mn[k] = run_min[k];
        mx[k] = run_max[k];
        ce[k] = word_t'((longint'(mn[k]) + longint'(mx[k])) >>> 1);
        sz[k] = clamp32(longint'(mx[k]) - longint'(mn[k]));
      end
      for (int i = 0; i < corn_count; i++) begin
        dx = longint'(corn_x[i]) - longint'(ce[0]);
        dy = longint'(corn_y[i]) - longint'(ce[1]);
        dz = longint'(corn_z[i]) - longint'(ce[2]);
        d = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
        if (d > best) best = d;
      end
      r = floor_sqrt(best);
      radius = (r > 64'd2147483647) ? 32'sh7fff_ffff : word_t'(r);
    end
    expect_result('{KIND_MIN, mn[0], mn[1], mn[2], 1'b0});
    expect_result('{KIND_MAX, mx[0], mx[1], mx[2], 1'b0});
    expect_result('{KIND_CENTER, ce[0], ce[1], ce[2], 1'b0});
    expect_result('{KIND_SIZE, sz[0], sz[1], sz[2], 1'b0});
    expect_result('{KIND_RADIUS, radius, 32'sd0, 32'sd0, 1'b1});
    clear_bounds();
  endtask

  task automatic predict_item(input logic [2:0] cmd, input word_t x, input word_t y,
                              input word_t z);
    if (cmd <= CMD_POSITION) begin
      part_vec[cmd][0] = x; part_vec[cmd][1] = y; part_vec[cmd][2] = z;
      if (cmd == CMD_POSITION) commit_corners();
    end else if (cmd == CMD_FINISH) begin
      finish_bounds();
    end
  endtask

  // Offer one item, with random idle gaps, and wait for its transfer
  task automatic send_item(input logic [2:0] cmd, input word_t x, input word_t y,
                           input word_t z);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_value_x <= x;
    in_value_y <= y;
    in_value_z <= z;
    do @(posedge clk); while (!in_ready);
    predict_item(cmd, x, y, z);
    if (cmd <= CMD_FINISH) items_sent++;
  endtask

  // Sender pause until every expected result is back, plus commit latency
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bounds_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random coordinate: mostly moderate values, some full range and extremes
  function automatic word_t rand_coord();
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      2:       return word_t'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
      default: return word_t'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  function automatic word_t rand_scale();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return word_t'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
      default: return word_t'($urandom_range(32'h0003_0000, 32'h0000_4000));
    endcase
  endfunction

  task automatic send_random_part();
    send_item(CMD_BOX_MIN, rand_coord(), rand_coord(), rand_coord());
    send_item(CMD_BOX_MAX, rand_coord(), rand_coord(), rand_coord());
    send_item(CMD_SCALE, rand_scale(), rand_scale(), rand_scale());
    send_item(CMD_ANGLES, $urandom, $urandom, $urandom);
    send_item(CMD_POSITION, rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_empty_and_spare();
    send_item(CMD_FINISH, $urandom, $urandom, $urandom);
    send_item(CMD_SPARE_6, $urandom, $urandom, $urandom);
    send_item(CMD_SPARE_7, $urandom, $urandom, $urandom);
    send_item(CMD_FINISH, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_directed();
    // Box from -1 to (1, 2, 3), identity transform
    send_item(CMD_BOX_MIN, -32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000);
    send_item(CMD_BOX_MAX, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    send_item(CMD_SCALE, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    send_item(CMD_ANGLES, '0, '0, '0);
    send_item(CMD_POSITION, '0, '0, '0);
    send_item(CMD_FINISH, '0, '0, '0);
    // Angles past a quarter turn fold; upper bits are ignored
    send_item(CMD_ANGLES, 32'hffff_2000, 32'h1234_d000, 32'h0000_7fff);
    send_item(CMD_POSITION, 32'sh0005_0000, -32'sh0003_0000, 32'sh0000_8000);
    send_item(CMD_ANGLES, 32'h0000_8000, 32'hffff_8000, 32'h5555_0c91);
    send_item(CMD_POSITION, '0, '0, '0);
    send_item(CMD_FINISH, '0, '0, '0);
    // Saturation at the extremes
    send_item(CMD_BOX_MIN, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_item(CMD_BOX_MAX, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(CMD_SCALE, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000);
    send_item(CMD_ANGLES, 32'h0000_0000, 32'h0000_1922, 32'h0000_0000);
    send_item(CMD_POSITION, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(CMD_FINISH, '0, '0, '0);
    send_item(CMD_ANGLES, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_item(CMD_POSITION, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(CMD_FINISH, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    wait_drained();
  endtask

  // More commits than the corner store holds; extras are dropped
  task automatic test_part_limit();
    send_item(CMD_SCALE, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    for (int i = 0; i < NUM_PARTS + 3; i++)
      send_item(CMD_POSITION, rand_coord(), rand_coord(), rand_coord());
    send_item(CMD_FINISH, '0, '0, '0);
    wait_drained();
  endtask

  // Receiver holds off while finishes pile up behind it
  task automatic test_backpressure();
    hold_left = 4000;
    send_item(CMD_FINISH, '0, '0, '0);
    send_random_part();
    send_item(CMD_FINISH, '0, '0, '0);
    send_random_part();
    send_item(CMD_FINISH, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(9))
        0: send_item(3'($urandom_range(7)), $urandom, $urandom, $urandom);
        1: send_item(3'($urandom_range(4)), rand_coord(), rand_coord(), rand_coord());
        2: send_item(CMD_FINISH, $urandom, $urandom, $urandom);
        default: begin
          send_random_part();
          if ($urandom_range(2) == 0) send_item(CMD_FINISH, $urandom, $urandom, $urandom);
        end
      endcase
    end
    send_item(CMD_FINISH, '0, '0, '0);
    wait_drained();
  endtask

  // Result checker and receiver ready
  always @(posedge clk) begin
    bounds_res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_kind, out_x, out_y, out_z, out_last};
      if (bounds_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d x %h y %h z %h last %b",
                   got.kind, got.x, got.y, got.z, got.last);
      end else begin
        want = bounds_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d x %h y %h z %h last %b, got kind %0d x %h y %h z %h last %b",
                     want.kind, want.x, want.y, want.z, want.last,
                     got.kind, got.x, got.y, got.z, got.last);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("transformed_box_bounds_with_sphere_core test failed");
      $finish;
    end
  end

  initial begin
    clear_bounds();
    for (int v = 0; v < 5; v++)
      for (int k = 0; k < 3; k++) part_vec[v][k] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 9; recv_idle = 54;
    test_empty_and_spare();
    test_directed();
    test_part_limit();
    test_backpressure();
    test_random(95);
    send_idle = 54; recv_idle = 9;
    test_random(95);
    send_idle = 0; recv_idle = 0;
    test_random(95);
    if (mismatches == 0 && bounds_q.size() == 0)
      $display("transformed_box_bounds_with_sphere_core test passed");
    else
      $display("transformed_box_bounds_with_sphere_core test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tbbs_pkg.sv
rtl/core/tbbs_ram.sv
rtl/core/tbbs_cordic.sv
rtl/core/tbbs_isqrt.sv
rtl/core/transformed_box_bounds_with_sphere_core.sv
sim/transformed_box_bounds_with_sphere_core_tb.sv
